// ----- rtl/cepc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cepc_pkg
// shared types, codes and defaults of the correctable error page collector
// ----------------------------------------------------------------------------
package cepc_pkg;

    localparam int PAGE_W     = 40;
    localparam int STATUS_W   = 3;
    localparam int USED_W     = 10;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [THR_W-1:0] THR_RESET = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE   = 1'd1;

    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OFFLINE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DECAYED  = 3'd4;

    localparam int DEF_MAX_ENTRIES    = 512;
    localparam int DEF_CLEAN_INTERVAL = 128;
    localparam int DEF_PAGE_BITS      = 40;
    localparam int DEF_COUNT_BITS     = 10;
    localparam int DEF_DECAY_BITS     = 2;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_INS,
        OP_DEL,
        OP_UPD,
        OP_AGE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/cepc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cepc_in_if
// request channel: error report or decay tick
// ----------------------------------------------------------------------------
interface cepc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [39:0] page_number;

    modport source (output valid, output cmd, output page_number, input ready);
    modport sink   (input valid, input cmd, input page_number, output ready);
endinterface
`default_nettype wire

// ----- rtl/cepc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cepc_out_if
// result channel of the collector
// ----------------------------------------------------------------------------
interface cepc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [39:0] offline_page;
    logic        evicted;
    logic [39:0] evicted_page;
    logic [9:0]  entries_used;

    modport source (output valid, output status, output offline_page, output evicted,
                    output evicted_page, output entries_used, input ready);
    modport sink   (input valid, input status, input offline_page, input evicted,
                    input evicted_page, input entries_used, output ready);
endinterface
`default_nettype wire

// ----- rtl/correctable_error_page_collector_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// correctable_error_page_collector_top
// sorted table of pages with correctable errors, kept in a ring of cells
// ----------------------------------------------------------------------------
// The table lives in a row of MAX_ENTRIES cells. A decay tick passes through an
// aging state and then the result load; a rejected report goes straight to the
// result load. An accepted error report rotates the whole ring once past a head
// comparator to find the lookup position, match and eviction candidate, then
// passes the evict and edit states, and the aging state when it triggers an
// aging pass. Edits (insert, delete, count update, aging) are applied to all
// cells in parallel. One item is worked on at a time; a new item may be accepted
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module correctable_error_page_collector_top
    import cepc_pkg::*;
#(
    parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
    parameter int CLEAN_INTERVAL = DEF_CLEAN_INTERVAL,
    parameter int PAGE_BITS      = DEF_PAGE_BITS,
    parameter int COUNT_BITS     = DEF_COUNT_BITS,
    parameter int DECAY_BITS     = DEF_DECAY_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    cepc_in_if.sink               i_in,
    cepc_out_if.source            o_out,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int N  = MAX_ENTRIES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int RW = $clog2(CLEAN_INTERVAL + 1);
    localparam int PB = PAGE_BITS;
    localparam int DB = DECAY_BITS;
    localparam int CB = COUNT_BITS;
    localparam int KW = DB + CB;
    localparam logic [CW-1:0] FULL    = CW'(N);
    localparam logic [IW-1:0] LAST    = IW'(N - 1);
    localparam logic [RW-1:0] CI      = RW'(CLEAN_INTERVAL);
    localparam logic [16:0]   CNT_MAX = 17'((1 << CB) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVICT,
        S_EDIT,
        S_AGE,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [PB-1:0]   r_page;
    logic [IW-1:0]   r_t;
    logic [CW-1:0]   r_lb;
    logic            r_found;
    logic [IW-1:0]   r_match_idx;
    logic [CB-1:0]   r_match_cnt;
    logic            r_have_best;
    logic [KW-1:0]   r_best_key;
    logic [IW-1:0]   r_best_idx;
    logic [PB-1:0]   r_best_page;
    logic [CW-1:0]   r_count;
    logic [RW-1:0]   r_rsc;
    logic [THR_W-1:0] r_thr;
    logic            r_dis;
    logic [STATUS_W-1:0] r_status;
    logic [PB-1:0]   r_offline;
    logic            r_evicted;
    logic [PB-1:0]   r_evpage;

    logic            r_ov;
    logic [STATUS_W-1:0] r_o_status;
    logic [PAGE_W-1:0] r_o_offline;
    logic            r_o_evicted;
    logic [PAGE_W-1:0] r_o_evpage;
    logic [USED_W-1:0] r_o_used;

    t_cell_ctl       w_ctl;
    logic [IW-1:0]   w_idx;
    logic [PB-1:0]   w_in_page;
    logic [PAGE_W-1:0] w_out_offline;
    logic [PAGE_W-1:0] w_out_evpage;

    logic [PB-1:0]   w_page  [N];
    logic [DB-1:0]   w_decay [N];
    logic [CB-1:0]   w_count [N];

    logic            w_accept;
    logic            w_h_valid;
    logic [KW-1:0]   w_h_key;
    logic [16:0]     w_thr_sat;
    logic            w_cnt_ok;
    logic [RW-1:0]   n_rsc;

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    generate
        if (PB > PAGE_W) begin : g_pg_wide
            assign w_in_page     = {{(PB - PAGE_W){1'b0}}, i_in.page_number};
            assign w_out_offline = r_offline[PAGE_W-1:0];
            assign w_out_evpage  = r_evpage[PAGE_W-1:0];
        end else if (PB == PAGE_W) begin : g_pg_same
            assign w_in_page     = i_in.page_number;
            assign w_out_offline = r_offline;
            assign w_out_evpage  = r_evpage;
        end else begin : g_pg_narrow
            assign w_in_page     = i_in.page_number[PB-1:0];
            assign w_out_offline = {{(PAGE_W - PB){1'b0}}, r_offline};
            assign w_out_evpage  = {{(PAGE_W - PB){1'b0}}, r_evpage};
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            cepc_cell #(
                .INDEX (gi),
                .IW    (IW),
                .PB    (PB),
                .DB    (DB),
                .CB    (CB)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_idx        (w_idx),
                .i_new_page   (r_page),
                .i_prev_page  (w_page [(gi + N - 1) % N]),
                .i_prev_decay (w_decay[(gi + N - 1) % N]),
                .i_prev_count (w_count[(gi + N - 1) % N]),
                .i_next_page  (w_page [(gi + 1) % N]),
                .i_next_decay (w_decay[(gi + 1) % N]),
                .i_next_count (w_count[(gi + 1) % N]),
                .o_page       (w_page[gi]),
                .o_decay      (w_decay[gi]),
                .o_count      (w_count[gi])
            );
        end
    endgenerate

    assign w_h_valid = CW'(r_t) < r_count;
    assign w_h_key   = {w_decay[0], w_count[0]};
    assign w_thr_sat = (17'(r_thr) > CNT_MAX) ? CNT_MAX : 17'(r_thr);
    assign w_cnt_ok  = 17'(r_match_cnt) < w_thr_sat;
    assign n_rsc     = r_rsc + RW'(1);

    always_comb begin
        w_ctl.op = OP_HOLD;
        w_idx    = r_match_idx;
        case (r_state)
            S_SCAN: begin
                w_ctl.op = OP_ROT;
            end
            S_EVICT: begin
                w_idx = r_best_idx;
                if (r_count == FULL) begin
                    w_ctl.op = OP_DEL;
                end
            end
            S_EDIT: begin
                if (!r_found) begin
                    w_ctl.op = OP_INS;
                    w_idx    = r_lb[IW-1:0];
                end else if (w_cnt_ok) begin
                    w_ctl.op = OP_UPD;
                end else begin
                    w_ctl.op = OP_DEL;
                end
            end
            S_AGE: begin
                w_ctl.op = OP_AGE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_dis <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_DISABLE:   r_dis <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rsc   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_out.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_page      <= w_in_page;
                        r_t         <= '0;
                        r_lb        <= '0;
                        r_found     <= 1'b0;
                        r_have_best <= 1'b0;
                        r_offline   <= '0;
                        r_evicted   <= 1'b0;
                        r_evpage    <= '0;
                        if (i_in.cmd) begin
                            r_status <= ST_DECAYED;
                            r_state  <= S_AGE;
                        end else if (r_dis) begin
                            r_status <= ST_REJECTED;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_h_valid) begin
                        if (w_page[0] < r_page) begin
                            r_lb <= r_lb + CW'(1);
                        end
                        if (w_page[0] == r_page) begin
                            r_found     <= 1'b1;
                            r_match_idx <= r_t;
                            r_match_cnt <= w_count[0];
                        end
                        if (!r_have_best || (w_h_key < r_best_key)) begin
                            r_have_best <= 1'b1;
                            r_best_key  <= w_h_key;
                            r_best_idx  <= r_t;
                            r_best_page <= w_page[0];
                        end
                    end
                    r_t <= r_t + IW'(1);
                    if (r_t == LAST) begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (r_count == FULL) begin
                        r_evicted <= 1'b1;
                        r_evpage  <= r_best_page;
                        r_count   <= r_count - CW'(1);
                        if (r_found && (r_match_idx == r_best_idx)) begin
                            r_found <= 1'b0;
                        end
                        if (r_best_idx < r_match_idx) begin
                            r_match_idx <= r_match_idx - IW'(1);
                        end
                        if (CW'(r_best_idx) < r_lb) begin
                            r_lb <= r_lb - CW'(1);
                        end
                    end
                    r_state <= S_EDIT;
                end
                S_EDIT: begin
                    if (!r_found) begin
                        r_status <= ST_NEW;
                        r_count  <= r_count + CW'(1);
                    end else if (w_cnt_ok) begin
                        r_status <= ST_COUNTED;
                    end else begin
                        r_status  <= ST_OFFLINE;
                        r_offline <= r_page;
                        r_count   <= r_count - CW'(1);
                    end
                    if (r_found && !w_cnt_ok) begin
                        r_state <= S_DONE;
                    end else if (n_rsc >= CI) begin
                        r_state <= S_AGE;
                    end else begin
                        r_rsc   <= n_rsc;
                        r_state <= S_DONE;
                    end
                end
                S_AGE: begin
                    r_rsc   <= '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov        <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_offline <= w_out_offline;
                        r_o_evicted <= r_evicted;
                        r_o_evpage  <= w_out_evpage;
                        r_o_used    <= USED_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_o_status;
    assign o_out.offline_page = r_o_offline;
    assign o_out.evicted      = r_o_evicted;
    assign o_out.evicted_page = r_o_evpage;
    assign o_out.entries_used = r_o_used;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above table size");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDIT && !r_found) |-> (r_count < FULL))
        else $error("insert into full table");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_t == LAST) |=> (r_state == S_EVICT))
        else $error("scan pass did not end after one rotation");

    a_tick_ages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.cmd) |=> (r_state == S_AGE))
        else $error("tick did not start an aging cycle");
`endif

endmodule
`default_nettype wire

// ----- rtl/cepc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cepc_cell
// one table slot: page, decay and count, shifts with its neighbors
// ----------------------------------------------------------------------------
module cepc_cell
    import cepc_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IW    = 9,
    parameter int PB    = DEF_PAGE_BITS,
    parameter int DB    = DEF_DECAY_BITS,
    parameter int CB    = DEF_COUNT_BITS
) (
    input  wire            i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire [IW-1:0]   i_idx,
    input  wire [PB-1:0]   i_new_page,
    input  wire [PB-1:0]   i_prev_page,
    input  wire [DB-1:0]   i_prev_decay,
    input  wire [CB-1:0]   i_prev_count,
    input  wire [PB-1:0]   i_next_page,
    input  wire [DB-1:0]   i_next_decay,
    input  wire [CB-1:0]   i_next_count,
    output logic [PB-1:0]  o_page,
    output logic [DB-1:0]  o_decay,
    output logic [CB-1:0]  o_count
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [DB-1:0] D_MAX  = {DB{1'b1}};

    logic [PB-1:0] r_page;
    logic [DB-1:0] r_decay;
    logic [CB-1:0] r_count;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_ROT: begin
                r_page  <= i_next_page;
                r_decay <= i_next_decay;
                r_count <= i_next_count;
            end
            OP_DEL: begin
                if (MY_IDX >= i_idx) begin
                    r_page  <= i_next_page;
                    r_decay <= i_next_decay;
                    r_count <= i_next_count;
                end
            end
            OP_INS: begin
                if (MY_IDX > i_idx) begin
                    r_page  <= i_prev_page;
                    r_decay <= i_prev_decay;
                    r_count <= i_prev_count;
                end else if (MY_IDX == i_idx) begin
                    r_page  <= i_new_page;
                    r_decay <= D_MAX;
                    r_count <= CB'(1);
                end
            end
            OP_UPD: begin
                if (MY_IDX == i_idx) begin
                    r_decay <= D_MAX;
                    r_count <= r_count + CB'(1);
                end
            end
            OP_AGE: begin
                if (r_decay != '0) begin
                    r_decay <= r_decay - DB'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_page  = r_page;
    assign o_decay = r_decay;
    assign o_count = r_count;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the correctable error page collector against a predictor of the
// sorted page table. Random idle bursts are applied on both channels, and the
// receiver holds off once for a long stretch. The test ends with a run of
// mostly fresh pages that grows the table.
// ----------------------------------------------------------------------------
module testbench;
    import cepc_pkg::*;

    localparam int TABLE_SIZE  = DEF_MAX_ENTRIES;
    localparam int CLEAN_EVERY = DEF_CLEAN_INTERVAL;
    localparam int SETTLE      = DEF_MAX_ENTRIES + 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] DECAY_FULL = 2'd3;

    typedef struct {
        logic        cmd;
        logic [39:0] page;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [39:0] offline_page;
        logic        evicted;
        logic [39:0] evicted_page;
        logic [9:0]  entries_used;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    cepc_in_if  req_if ();
    cepc_out_if res_if ();

    correctable_error_page_collector_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;
    bit   req_done = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_cycles = 0;
    bit   start_hold = 1'b0;

    // predictor copy of the page table
    logic [39:0] tab_page[TABLE_SIZE];
    logic [1:0]  tab_decay[TABLE_SIZE];
    logic [9:0]  tab_count[TABLE_SIZE];
    int          used = 0;
    int          since_clean = 0;
    logic [9:0]  threshold = THR_RESET;
    logic        disabled = 1'b0;
    logic [39:0] pool[24];

    initial begin
        req_if.valid = 1'b0;
        req_if.cmd = 1'b0;
        req_if.page_number = '0;
        res_if.ready = 1'b0;
    end

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task automatic age_pages();
        for (int i = 0; i < used; i++) begin
            if (tab_decay[i] != 0) tab_decay[i]--;
        end
        since_clean = 0;
    endtask

    task automatic remove_page(input int idx);
        for (int i = idx; i < used - 1; i++) begin
            tab_page[i] = tab_page[i+1];
            tab_decay[i] = tab_decay[i+1];
            tab_count[i] = tab_count[i+1];
        end
        used--;
    endtask

    task automatic predict_page_report(input t_req rq);
        t_res r;
        int idx;
        int best;
        int best_key;
        r.status = ST_REJECTED;
        r.offline_page = '0;
        r.evicted = 1'b0;
        r.evicted_page = '0;
        if (rq.cmd) begin
            age_pages();
            r.status = ST_DECAYED;
        end else if (!disabled) begin
            if (used >= TABLE_SIZE) begin
                best = 0;
                best_key = 1 << 20;
                for (int i = 0; i < used; i++) begin
                    if (int'({tab_decay[i], tab_count[i]}) < best_key) begin
                        best_key = int'({tab_decay[i], tab_count[i]});
                        best = i;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = tab_page[best];
                remove_page(best);
            end
            idx = 0;
            while (idx < used && tab_page[idx] < rq.page) idx++;
            if (idx >= used || tab_page[idx] != rq.page) begin
                for (int i = used; i > idx; i--) begin
                    tab_page[i] = tab_page[i-1];
                    tab_decay[i] = tab_decay[i-1];
                    tab_count[i] = tab_count[i-1];
                end
                tab_page[idx] = rq.page;
                tab_decay[idx] = DECAY_FULL;
                tab_count[idx] = 10'd1;
                used++;
                r.status = ST_NEW;
            end else if (tab_count[idx] < threshold) begin
                tab_decay[idx] = DECAY_FULL;
                tab_count[idx]++;
                r.status = ST_COUNTED;
            end else begin
                r.offline_page = tab_page[idx];
                remove_page(idx);
                r.status = ST_OFFLINE;
            end
            if (r.status != ST_OFFLINE) begin
                since_clean++;
                if (since_clean >= CLEAN_EVERY) age_pages();
            end
        end
        r.entries_used = 10'(used);
        expected_results.push_back(r);
    endtask

    // input monitor and result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_page_report('{cmd: req_if.cmd, page: req_if.page_number});
            req_done = 1'b1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected transfer", {37'd0, res_if.status}, '0);
            end else begin
                e = expected_results.pop_front();
                if (res_if.status !== e.status)
                    report("status", 40'(res_if.status), 40'(e.status));
                if (res_if.offline_page !== e.offline_page)
                    report("offline_page", res_if.offline_page, e.offline_page);
                if (res_if.evicted !== e.evicted)
                    report("evicted", 40'(res_if.evicted), 40'(e.evicted));
                if (res_if.evicted_page !== e.evicted_page)
                    report("evicted_page", res_if.evicted_page, e.evicted_page);
                if (res_if.entries_used !== e.entries_used)
                    report("entries_used", 40'(res_if.entries_used), 40'(e.entries_used));
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_req rq;
        if (req_done || !req_if.valid) begin
            req_done = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                req_if.valid <= 1'b0;
            end else if (i_rst_n && pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.cmd <= rq.cmd;
                req_if.page_number <= rq.page;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (start_hold) begin
            start_hold <= 1'b0;
            hold_cycles <= 3000;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            res_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 12) - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(input logic cmd, input logic [39:0] page);
        pending_reqs.push_back('{cmd: cmd, page: page});
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD) threshold = val;
        else disabled = val[0];
    endtask

    function automatic logic [39:0] any_page();
        return 40'({$urandom, $urandom});
    endfunction

    initial begin
        int pick;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (pool[i]) pool[i] = any_page();
        pool[0] = '0;
        pool[1] = '1;

        // extremes, repeats and decay down to zero
        send(1'b1, '0);
        send(1'b0, '0);
        send(1'b0, '1);
        send(1'b0, '0);
        repeat (4) send(1'b1, any_page());
        send(1'b0, '1);
        send(1'b0, 40'h55_5555_5555);
        send(1'b0, 40'hAA_AAAA_AAAA);
        drain();

        // threshold zero: a known page goes offline at once
        write_reg(CFG_THRESHOLD, 10'd0);
        send(1'b0, '0);
        send(1'b0, 40'd5);
        send(1'b0, 40'd5);
        drain();

        write_reg(CFG_DISABLE, 1'd1);
        send(1'b0, 40'd7);
        send(1'b0, '1);
        send(1'b1, '0);
        drain();
        write_reg(CFG_DISABLE, 1'd0);

        // random part on a small pool so counts reach the threshold
        write_reg(CFG_THRESHOLD, 10'd3);
        start_hold = 1'b1;
        for (int n = 0; n < 110; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) send(1'b1, any_page());
            else if (pick == 1) send(1'b0, any_page());
            else send(1'b0, pool[$urandom_range(0, 23)]);
        end
        drain();

        // mostly fresh pages to grow the table
        write_reg(CFG_THRESHOLD, 10'd1023);
        quiet = 1'b1;
        for (int n = 0; n < 160; n++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send(1'b1, any_page());
            else if (pick < 3) send(1'b0, pool[$urandom_range(0, 23)]);
            else send(1'b0, any_page());
        end
        drain();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
